// ----- design/lfe_pkg.sv -----
// Shared types and constants for the LED fade envelope.
package lfe_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_FIN  = 2'd2,
    MODE_FOUT = 2'd3
  } mode_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [7:0] ALPHA_MAX = 8'd255;
  localparam logic [7:0] ALPHA_MIN = 8'd0;

  localparam int DUR_RESET = 1000;

endpackage

// ----- design/led_fade_envelope.sv -----
// LED fade envelope: mode sequencer around one shared serial divider.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   in      | input     | in_valid, in_stall, in_operation, in_delta_time,
//           |           | in_new_mode
//   out     | output    | out_valid, out_stall, out_alpha, out_mode, out_active
//   cfg     | input     | cfg_wr_en, cfg_wr_data (fade length in ticks)
//
// A transaction that needs no division (tick outside a fade, tick that ends a
// fade, start of off or on) goes from S_EXEC straight to S_OUT. A tick inside
// a fade, or a start of fade-in or fade-out, also passes through S_DIV for the
// divider start, one pass of the serial divider and its finish. The next
// transaction is taken only once the result is loaded and the block is idle.
// Reset gives mode on, alpha 255, elapsed time 0 and duration 1000.
// in_stall is high from accept until the result is loaded into the output
// register; a held result on a stalled output holds the sequencer too.
module led_fade_envelope #(
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TIME_BITS-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [TIME_BITS-1:0] in_delta_time,
  input  logic [1:0]           in_new_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_alpha,
  output logic [1:0]           out_mode,
  output logic                 out_active
);

  localparam int DVD_W = TIME_BITS + 8;
  localparam int ET_W  = TIME_BITS + 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_OUT} state_t;

  state_t                 state_r;
  lfe_pkg::mode_t         mode_r;
  logic [ET_W-1:0]        elapsed_r;
  logic [7:0]             alpha_r;
  logic [TIME_BITS-1:0]   dur_r;

  logic                   op_r;
  logic [TIME_BITS-1:0]   delta_r;
  logic [1:0]             req_r;
  logic                   ramp_r;

  logic                   div_start_r;
  logic [DVD_W-1:0]       div_dividend_r;
  logic [TIME_BITS-1:0]   div_divisor_r;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quotient;

  logic                   out_valid_r;
  logic [7:0]             out_alpha_r;
  logic [1:0]             out_mode_r;
  logic                   out_active_r;

  logic [ET_W:0]          tsum;
  logic [ET_W-1:0]        tsat;
  logic                   fade_end;
  logic [DVD_W-1:0]       ramp_dividend;
  logic [7:0]             mul_a;
  logic [DVD_W-1:0]       resume_prod;
  logic                   out_free;

  always_comb begin
    tsum          = {1'b0, elapsed_r} + {2'b00, delta_r};
    tsat          = tsum[ET_W] ? {ET_W{1'b1}} : tsum[ET_W-1:0];
    fade_end      = (tsat >= {1'b0, dur_r});
    // t*255 as (t << 8) - t; t < duration here, so t fits TIME_BITS bits
    ramp_dividend = {tsat[TIME_BITS-1:0], 8'd0} - {8'd0, tsat[TIME_BITS-1:0]};
    mul_a         = (lfe_pkg::mode_t'(req_r) == lfe_pkg::MODE_FIN) ?
                    alpha_r : (lfe_pkg::ALPHA_MAX - alpha_r);
    resume_prod   = DVD_W'(mul_a * dur_r);
    out_free      = !out_valid_r || !out_stall;
  end

  lfe_divider #(
    .DIVIDEND_W (DVD_W),
    .DIVISOR_W  (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend_r),
    .divisor  (div_divisor_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= TIME_BITS'(lfe_pkg::DUR_RESET);
    end else if (cfg_wr_en) begin
      dur_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= lfe_pkg::MODE_ON;
      elapsed_r    <= '0;
      alpha_r      <= lfe_pkg::ALPHA_MAX;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      op_r         <= lfe_pkg::OP_TICK;
      delta_r      <= '0;
      req_r        <= '0;
      ramp_r       <= 1'b0;
      div_dividend_r <= '0;
      div_divisor_r  <= '0;
      out_alpha_r  <= '0;
      out_mode_r   <= '0;
      out_active_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            delta_r <= in_delta_time;
            req_r   <= in_new_mode;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          state_r <= S_OUT;
          if (op_r == lfe_pkg::OP_TICK) begin
            if (mode_r == lfe_pkg::MODE_FIN || mode_r == lfe_pkg::MODE_FOUT) begin
              if (fade_end) begin
                elapsed_r <= '0;
                if (mode_r == lfe_pkg::MODE_FIN) begin
                  mode_r  <= lfe_pkg::MODE_ON;
                  alpha_r <= lfe_pkg::ALPHA_MAX;
                end else begin
                  mode_r  <= lfe_pkg::MODE_OFF;
                  alpha_r <= lfe_pkg::ALPHA_MIN;
                end
              end else begin
                // alpha = t*255/duration
                elapsed_r      <= tsat;
                div_dividend_r <= ramp_dividend;
                div_divisor_r  <= dur_r;
                div_start_r    <= 1'b1;
                ramp_r         <= 1'b1;
                state_r        <= S_DIV;
              end
            end
          end else begin
            unique case (lfe_pkg::mode_t'(req_r))
              lfe_pkg::MODE_OFF: begin
                mode_r  <= lfe_pkg::MODE_OFF;
                alpha_r <= lfe_pkg::ALPHA_MIN;
              end
              lfe_pkg::MODE_ON: begin
                mode_r    <= lfe_pkg::MODE_ON;
                elapsed_r <= '0;
                alpha_r   <= lfe_pkg::ALPHA_MAX;
              end
              lfe_pkg::MODE_FIN, lfe_pkg::MODE_FOUT: begin
                // resume point: t = alpha*duration/255 (or 255-alpha)
                mode_r         <= lfe_pkg::mode_t'(req_r);
                div_dividend_r <= resume_prod;
                div_divisor_r  <= TIME_BITS'(lfe_pkg::ALPHA_MAX);
                div_start_r    <= 1'b1;
                ramp_r         <= 1'b0;
                state_r        <= S_DIV;
              end
            endcase
          end
        end

        S_DIV: begin
          if (div_done) begin
            if (ramp_r) begin
              alpha_r <= (mode_r == lfe_pkg::MODE_FIN) ? div_quotient[7:0] :
                         (lfe_pkg::ALPHA_MAX - div_quotient[7:0]);
            end else begin
              elapsed_r <= {1'b0, div_quotient[TIME_BITS-1:0]};
            end
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_alpha_r  <= alpha_r;
            out_mode_r   <= mode_r;
            out_active_r <= (mode_r != lfe_pkg::MODE_OFF);
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_alpha  = out_alpha_r;
  assign out_mode   = out_mode_r;
  assign out_active = out_active_r;

endmodule

// ----- design/lfe_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module lfe_divider #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      count_r;
  logic                  done_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W-1:0]  rem_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, dvd_r[DIVIDEND_W-1]};
    ge    = (trial >= {1'b0, dsr_r});
    diff  = trial - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        count_r <= CNT_W'(DIVIDEND_W);
      end else if (count_r != '0) begin
        count_r <= count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend bits as they are consumed
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (count_r != '0) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the LED fade envelope with a built-in envelope predictor.
`timescale 1ns / 100ps

module tb;

  localparam int TIME_BITS   = 16;
  localparam int HOLD_LEN    = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL        = 2 * (TIME_BITS + 12);
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic                 op;
    logic [TIME_BITS-1:0] delta;
    lfe_pkg::mode_t       nmode;
  } fade_cmd_t;

  typedef struct packed {
    logic [7:0]     alpha;
    lfe_pkg::mode_t mode;
    logic           active;
  } fade_view_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [TIME_BITS-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = lfe_pkg::OP_TICK;
  logic [TIME_BITS-1:0] in_delta_time = '0;
  logic [1:0]           in_new_mode = lfe_pkg::MODE_OFF;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_alpha;
  logic [1:0]           out_mode;
  logic                 out_active;

  // predictor state
  lfe_pkg::mode_t       env_mode = lfe_pkg::MODE_ON;
  logic [TIME_BITS:0]   env_ticks = '0;
  logic [7:0]           env_alpha = lfe_pkg::ALPHA_MAX;
  logic [TIME_BITS-1:0] env_dur = TIME_BITS'(lfe_pkg::DUR_RESET);

  fade_cmd_t  cmd_q[$];
  fade_view_t envelope_q[$];
  fade_cmd_t  drive_cmd;
  fade_view_t seen_view;
  fade_view_t want_view;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_arm = 1'b0;
  int quiet_cycles = 0;
  int err_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int fades_ended = 0;
  int dur_writes = 0;

  logic [TIME_BITS-1:0] dur_plan [RAND_PHASES] =
    '{16'd1, 16'd65535, 16'd7, 16'd255, 16'd1000, 16'd0, 16'd3, 16'd40};

  always #5 clk = ~clk;

  led_fade_envelope #(.TIME_BITS(TIME_BITS)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_delta_time (in_delta_time),
    .in_new_mode   (in_new_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_alpha     (out_alpha),
    .out_mode      (out_mode),
    .out_active    (out_active)
  );

  function automatic fade_view_t advance_envelope(fade_cmd_t c);
    logic [TIME_BITS+1:0] t;
    logic [31:0]          ramp;
    fade_view_t           v;
    if (c.op == lfe_pkg::OP_TICK) begin
      if (env_mode == lfe_pkg::MODE_FIN || env_mode == lfe_pkg::MODE_FOUT) begin
        t = {1'b0, env_ticks} + c.delta;
        if (t > {1'b0, {(TIME_BITS+1){1'b1}}}) t = {1'b0, {(TIME_BITS+1){1'b1}}};
        if (t >= env_dur) begin
          env_mode = (env_mode == lfe_pkg::MODE_FIN) ? lfe_pkg::MODE_ON : lfe_pkg::MODE_OFF;
          env_ticks = '0;
          env_alpha = (env_mode == lfe_pkg::MODE_ON) ? lfe_pkg::ALPHA_MAX : lfe_pkg::ALPHA_MIN;
          fades_ended++;
        end else begin
          // t < duration here, so the duration is nonzero
          ramp = (32'(t) * 255) / 32'(env_dur);
          env_ticks = t[TIME_BITS:0];
          env_alpha = (env_mode == lfe_pkg::MODE_FIN) ? ramp[7:0] :
                      lfe_pkg::ALPHA_MAX - ramp[7:0];
        end
      end
    end else begin
      case (c.nmode)
        lfe_pkg::MODE_OFF: begin
          env_mode = lfe_pkg::MODE_OFF;
          env_alpha = lfe_pkg::ALPHA_MIN;
        end
        lfe_pkg::MODE_ON: begin
          env_mode = lfe_pkg::MODE_ON;
          env_ticks = '0;
          env_alpha = lfe_pkg::ALPHA_MAX;
        end
        lfe_pkg::MODE_FIN: begin
          // resume from the present brightness
          env_ticks = (TIME_BITS+1)'((32'(env_alpha) * 32'(env_dur)) / 255);
          env_mode = lfe_pkg::MODE_FIN;
        end
        default: begin
          env_ticks = (TIME_BITS+1)'((32'(lfe_pkg::ALPHA_MAX - env_alpha) *
                                      32'(env_dur)) / 255);
          env_mode = lfe_pkg::MODE_FOUT;
        end
      endcase
    end
    v.alpha = env_alpha;
    v.mode = env_mode;
    v.active = (env_mode != lfe_pkg::MODE_OFF);
    return v;
  endfunction

  task automatic push_item(logic op, logic [TIME_BITS-1:0] delta, lfe_pkg::mode_t nmode);
    fade_cmd_t c;
    c.op = op;
    c.delta = delta;
    c.nmode = nmode;
    cmd_q.push_back(c);
  endtask

  // Write the duration while the block is idle, then mirror it in the predictor.
  task automatic set_duration(logic [TIME_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    env_dur = value;
    dur_writes++;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (cmd_q.size() != 0 || in_valid || envelope_q.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        envelope_q.push_back(advance_envelope(drive_cmd));
        sent_cnt++;
      end
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_cmd = cmd_q.pop_front();
        in_valid <= 1'b1;
        in_operation <= drive_cmd.op;
        in_delta_time <= drive_cmd.delta;
        in_new_mode <= drive_cmd.nmode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_view.alpha = out_alpha;
      seen_view.mode = lfe_pkg::mode_t'(out_mode);
      seen_view.active = out_active;
      if (envelope_q.size() == 0) begin
        $display("%0t: unexpected result alpha=%0d mode=%0d active=%0d",
                 $time, seen_view.alpha, seen_view.mode, seen_view.active);
        err_cnt++;
      end else begin
        want_view = envelope_q.pop_front();
        checked_cnt++;
        if (seen_view.alpha !== want_view.alpha || seen_view.mode !== want_view.mode ||
            seen_view.active !== want_view.active) begin
          $display("%0t: mismatch: expected alpha=%0d mode=%0d active=%0d,",
                   $time, want_view.alpha, want_view.mode, want_view.active);
          $display("    got alpha=%0d mode=%0d active=%0d",
                   seen_view.alpha, seen_view.mode, seen_view.active);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, envelope_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int                   r;
    logic [TIME_BITS-1:0] dsel;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset duration: fade-out, resume into fade-in, run out, start from off
    push_item(lfe_pkg::OP_TICK,  16'd0,     lfe_pkg::MODE_OFF);
    push_item(lfe_pkg::OP_START, 16'hFFFF,  lfe_pkg::MODE_FOUT);
    push_item(lfe_pkg::OP_TICK,  16'd1,     lfe_pkg::MODE_ON);
    push_item(lfe_pkg::OP_TICK,  16'd499,   lfe_pkg::MODE_FOUT);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_FIN);
    push_item(lfe_pkg::OP_TICK,  16'd0,     lfe_pkg::MODE_FIN);
    push_item(lfe_pkg::OP_TICK,  16'hFFFF,  lfe_pkg::MODE_OFF);
    push_item(lfe_pkg::OP_START, 16'h5555,  lfe_pkg::MODE_OFF);
    push_item(lfe_pkg::OP_TICK,  16'hFFFF,  lfe_pkg::MODE_FOUT);
    push_item(lfe_pkg::OP_START, 16'hAAAA,  lfe_pkg::MODE_FIN);
    push_item(lfe_pkg::OP_TICK,  16'd999,   lfe_pkg::MODE_ON);
    wait_drained();

    // shorten the duration mid-fade: next tick ends it
    set_duration(16'd10);
    push_item(lfe_pkg::OP_TICK,  16'd0,     lfe_pkg::MODE_OFF);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_FOUT);
    push_item(lfe_pkg::OP_TICK,  16'd5,     lfe_pkg::MODE_ON);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_ON);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_FIN);
    push_item(lfe_pkg::OP_TICK,  16'd0,     lfe_pkg::MODE_FIN);
    wait_drained();

    // zero duration
    set_duration(16'd0);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_FOUT);
    push_item(lfe_pkg::OP_TICK,  16'd0,     lfe_pkg::MODE_FOUT);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_FIN);
    push_item(lfe_pkg::OP_TICK,  16'd0,     lfe_pkg::MODE_FIN);
    wait_drained();

    set_duration(16'hFFFF);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_OFF);
    push_item(lfe_pkg::OP_START, 16'd0,     lfe_pkg::MODE_FIN);
    push_item(lfe_pkg::OP_TICK,  16'hFFFE,  lfe_pkg::MODE_OFF);
    push_item(lfe_pkg::OP_TICK,  16'hFFFF,  lfe_pkg::MODE_OFF);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      dsel = (ph == 5) ? TIME_BITS'($urandom_range(65535)) : dur_plan[ph];
      set_duration(dsel);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 22) begin
          // starts lean toward fades so ticks have something to advance
          push_item(lfe_pkg::OP_START, TIME_BITS'($urandom),
                    ($urandom_range(3) == 0) ? lfe_pkg::mode_t'($urandom_range(3)) :
                    ($urandom_range(1) == 1) ? lfe_pkg::MODE_FIN : lfe_pkg::MODE_FOUT);
        end else if (r < 82) begin
          push_item(lfe_pkg::OP_TICK, TIME_BITS'($urandom_range((32'(env_dur) >> 4) + 1)),
                    lfe_pkg::mode_t'($urandom_range(3)));
        end else if (r < 92) begin
          push_item(lfe_pkg::OP_TICK, TIME_BITS'($urandom),
                    lfe_pkg::mode_t'($urandom_range(3)));
        end else begin
          push_item(lfe_pkg::OP_TICK, TIME_BITS'($urandom_range(3)),
                    lfe_pkg::mode_t'($urandom_range(3)));
        end
      end
      if (ph == 4) begin
        // hold the output while the sender keeps offering
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end
      wait_drained();
    end

    repeat (TAIL) @(posedge clk);
    if (envelope_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, envelope_q.size());
      err_cnt++;
    end
    $display("Covered %0d tick/start transactions, %0d results compared, %0d fades run out,",
             sent_cnt, checked_cnt, fades_ended);
    $display("under %0d duration writes including zero and full scale, with idle and stall phases",
             dur_writes);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
